>>> rtl/core/flv_avc_tag_to_annexb_top_defines.svh
`ifndef FLV_AVC_TAG_TO_ANNEXB_TOP_DEFINES_SVH
`define FLV_AVC_TAG_TO_ANNEXB_TOP_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define FLV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define FLV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/flv_annexb_pkg.sv
package flv_annexb_pkg;

    localparam int unsigned CfgWidth = 3;

    // results caused by one accepted byte
    typedef struct packed {
        logic        start_code;
        logic        insert_ps;
        logic        data;
        logic [7:0]  data_byte;
        logic        end_report;
        logic [2:0]  status;
        logic [31:0] pts;
        logic [31:0] dts;
    } group_t;

endpackage

>>> rtl/core/flv_annexb_in_if.sv
interface flv_annexb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_of_tag;
    logic [23:0] tag_length;
    logic [31:0] timestamp;

    modport source (output valid, data_byte, first_of_tag, tag_length, timestamp,
                    input ready);
    modport sink (input valid, data_byte, first_of_tag, tag_length, timestamp,
                  output ready);
endinterface

>>> rtl/core/flv_annexb_out_if.sv
interface flv_annexb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_data;
    logic        insert_parameter_sets;
    logic        end_of_tag;
    logic [2:0]  tag_status;
    logic [31:0] pts;
    logic [31:0] dts;

    modport source (output valid, out_byte, is_data, insert_parameter_sets, end_of_tag,
                    tag_status, pts, dts, input ready);
    modport sink (input valid, out_byte, is_data, insert_parameter_sets, end_of_tag,
                  tag_status, pts, dts, output ready);
endinterface

>>> rtl/core/flv_avc_tag_to_annexb_top.sv
// a result is valid in the cycle after the transfer of its input byte
// throughput: one input byte per cycle while the output is ready and each byte
//   yields at most one result; each result beyond the first holds the input back:
//   the start code before a nal's first byte, all but one start code byte of an
//   empty nal, an end report behind other results, and any output stalls
// reset (rst_n low, asynchronous): parser idle, nal_length_size back to 4, no results
module flv_avc_tag_to_annexb_top
    import flv_annexb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgWidth-1:0] cfg_wdata,
    flv_annexb_in_if.sink       tag_stream,
    flv_annexb_out_if.source    annexb_stream
);

    // nal length prefix size register
    logic [CfgWidth-1:0] nal_length_size_reg;

    // emitter registers: results of the last accepted byte still to leave
    logic [2:0]  sc_left_reg, sc_left_next;   // start code bytes still to send
    logic        ins_reg, ins_next;
    logic        data_reg, data_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] pts_reg, pts_next;
    logic [31:0] dts_reg, dts_next;

    group_t group;
    logic   in_xfer;
    logic   out_xfer;
    logic   empty;
    logic   last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nal_length_size_reg <= CfgWidth'(4);
        end
        else if (cfg_we)
        begin
            nal_length_size_reg <= cfg_wdata;
        end
    end

    // parse state machine, updated on each input transfer
    flv_annexb_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_xfer),
        .data_byte       (tag_stream.data_byte),
        .first_of_tag    (tag_stream.first_of_tag),
        .tag_length      (tag_stream.tag_length),
        .timestamp       (tag_stream.timestamp),
        .nal_length_size (nal_length_size_reg),
        .group           (group)
    );

    assign empty = (sc_left_reg == 3'd0) && !data_reg && !end_reg;

    // the result on the port is the final one of its group
    assign last = ((sc_left_reg == 3'd1) && !data_reg && !end_reg) ||
                  ((sc_left_reg == 3'd0) && data_reg && !end_reg) ||
                  ((sc_left_reg == 3'd0) && !data_reg && end_reg);

    assign out_xfer = annexb_stream.valid && annexb_stream.ready;

    // take a new byte once the emitter is empty or its last result is leaving
    assign tag_stream.ready = empty || (out_xfer && last);
    assign in_xfer          = tag_stream.valid && tag_stream.ready;

    always_comb
    begin
        sc_left_next = sc_left_reg;
        ins_next     = ins_reg;
        data_next    = data_reg;
        byte_next    = byte_reg;
        end_next     = end_reg;
        status_next  = status_reg;
        pts_next     = pts_reg;
        dts_next     = dts_reg;
        if (in_xfer)
        begin
            sc_left_next = group.start_code ? 3'd4 : 3'd0;
            ins_next     = group.insert_ps;
            data_next    = group.data;
            byte_next    = group.data_byte;
            end_next     = group.end_report;
            status_next  = group.status;
            pts_next     = group.pts;
            dts_next     = group.dts;
        end
        else if (out_xfer)
        begin
            if (sc_left_reg != 3'd0)
            begin
                sc_left_next = sc_left_reg - 3'd1;
            end
            else if (data_reg)
            begin
                data_next = 1'b0;
            end
            else
            begin
                end_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_left_reg <= '0;
            data_reg    <= 1'b0;
            end_reg     <= 1'b0;
        end
        else
        begin
            sc_left_reg <= sc_left_next;
            data_reg    <= data_next;
            end_reg     <= end_next;
        end
    end

    // payload of the emitter, no reset needed
    always_ff @(posedge clk)
    begin
        ins_reg    <= ins_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        pts_reg    <= pts_next;
        dts_reg    <= dts_next;
    end

    // output mux: start code first, then the nal or raw byte, then the end report
    always_comb
    begin
        annexb_stream.valid                 = !empty;
        annexb_stream.out_byte              = 8'd0;
        annexb_stream.is_data               = 1'b0;
        annexb_stream.insert_parameter_sets = 1'b0;
        annexb_stream.end_of_tag            = 1'b0;
        annexb_stream.tag_status            = 3'd0;
        annexb_stream.pts                   = 32'd0;
        annexb_stream.dts                   = 32'd0;
        if (sc_left_reg != 3'd0)
        begin
            annexb_stream.is_data               = 1'b1;
            annexb_stream.out_byte              = (sc_left_reg == 3'd1) ? 8'h01 : 8'h00;
            annexb_stream.insert_parameter_sets = ins_reg && (sc_left_reg == 3'd4);
        end
        else if (data_reg)
        begin
            annexb_stream.is_data  = 1'b1;
            annexb_stream.out_byte = byte_reg;
        end
        else if (end_reg)
        begin
            annexb_stream.end_of_tag = 1'b1;
            annexb_stream.tag_status = status_reg;
            annexb_stream.pts        = pts_reg;
            annexb_stream.dts        = dts_reg;
        end
    end

endmodule

>>> rtl/core/flv_annexb_parser.sv
module flv_annexb_parser
    import flv_annexb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                first_of_tag,
    input  logic [23:0]         tag_length,
    input  logic [31:0]         timestamp,
    input  logic [CfgWidth-1:0] nal_length_size,
    output group_t              group
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_HEADER   = 3'd1;
    localparam logic [2:0] PH_LENGTH   = 3'd2;
    localparam logic [2:0] PH_NALFIRST = 3'd3;
    localparam logic [2:0] PH_NALBODY  = 3'd4;
    localparam logic [2:0] PH_RAW      = 3'd5;
    localparam logic [2:0] PH_SKIP     = 3'd6;

    localparam logic [2:0] ST_NALU_OK  = 3'd0;
    localparam logic [2:0] ST_SEQ_RAW  = 3'd1;
    localparam logic [2:0] ST_OTHER    = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;

    localparam logic [3:0]  CODEC_AVC   = 4'd7;
    localparam logic [4:0]  NAL_IDR     = 5'd5;
    localparam logic [4:0]  NAL_SPS     = 5'd7;
    localparam logic [4:0]  NAL_PPS     = 5'd8;
    localparam logic [23:0] AVC_HDR_LEN = 24'd5;
    localparam logic [23:0] SEQ_MIN_LEN = 24'(5 + 7);

    logic [23:0] pos_reg, pos_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  lbs_reg, lbs_next;
    logic [23:0] left_reg, left_next;
    logic        pss_reg, pss_next;
    logic        kind_zero_reg, kind_zero_next;
    logic [23:0] ct_reg, ct_next;
    logic [31:0] ts_reg, ts_next;
    logic [23:0] len_reg, len_next;
    logic [2:0]  err_reg, err_next;

    logic [2:0]  nsz;
    logic        open;
    logic [23:0] pos_base;
    logic [23:0] len_eff;
    logic [31:0] acc_new;
    logic [2:0]  lbs_new;
    logic [23:0] remaining;
    logic [31:0] nal_len;
    logic [24:0] pos_inc;

    always_comb
    begin
        if (nal_length_size == 3'd0)
        begin
            nsz = 3'd1;
        end
        else if (nal_length_size > 3'd4)
        begin
            nsz = 3'd4;
        end
        else
        begin
            nsz = nal_length_size;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        lbs_next       = lbs_reg;
        left_next      = left_reg;
        pss_next       = pss_reg;
        kind_zero_next = kind_zero_reg;
        ct_next        = ct_reg;
        ts_next        = ts_reg;
        len_next       = len_reg;
        err_next       = err_reg;
        group          = '0;
        open           = 1'b0;
        pos_base       = pos_reg;
        len_eff        = (tag_length == 24'd0) ? 24'd1 : tag_length;
        acc_new        = {acc_reg[23:0], data_byte};
        lbs_new        = lbs_reg + 3'd1;
        remaining      = len_reg - pos_reg - 24'd1;
        nal_len        = (acc_new == 32'd1) ? {8'd0, remaining} : acc_new;
        pos_inc        = 25'd0;

        if (first_of_tag)
        begin
            open           = 1'b1;
            pos_base       = 24'd0;
            len_next       = len_eff;
            ts_next        = timestamp;
            acc_next       = '0;
            lbs_next       = '0;
            left_next      = '0;
            pss_next       = 1'b0;
            kind_zero_next = 1'b1;
            ct_next        = '0;
            if (data_byte[3:0] == CODEC_AVC)
            begin
                if (len_eff < AVC_HDR_LEN)
                begin
                    err_next   = ST_SHORT;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    err_next   = ST_NALU_OK;
                    phase_next = PH_HEADER;
                end
            end
            else
            begin
                err_next   = ST_OTHER;
                phase_next = PH_RAW;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            open = 1'b1;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == 24'd1)
                    begin
                        kind_zero_next = (data_byte == 8'd0);
                    end
                    else
                    begin
                        ct_next = {ct_reg[15:0], data_byte};
                        if (pos_reg >= 24'd4)
                        begin
                            if (kind_zero_reg)
                            begin
                                if (len_reg > SEQ_MIN_LEN)
                                begin
                                    err_next   = ST_SEQ_RAW;
                                    phase_next = PH_RAW;
                                end
                                else
                                begin
                                    err_next   = ST_SHORT;
                                    phase_next = PH_SKIP;
                                end
                            end
                            else
                            begin
                                err_next   = ST_NALU_OK;
                                acc_next   = '0;
                                lbs_next   = '0;
                                phase_next = PH_LENGTH;
                            end
                        end
                    end
                end
                PH_LENGTH:
                begin
                    // a prefix needs at least one byte after it
                    if (lbs_reg == 3'd0 &&
                        !(({1'b0, pos_reg} + {22'd0, nsz}) < {1'b0, len_reg}))
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (lbs_new >= nsz)
                    begin
                        acc_next = '0;
                        lbs_next = '0;
                        if (nal_len > {8'd0, remaining})
                        begin
                            err_next   = ST_BAD_SIZE;
                            phase_next = PH_SKIP;
                        end
                        else if (nal_len == 32'd0)
                        begin
                            group.start_code = 1'b1;
                        end
                        else
                        begin
                            left_next  = nal_len[23:0];
                            phase_next = PH_NALFIRST;
                        end
                    end
                    else
                    begin
                        acc_next = acc_new;
                        lbs_next = lbs_new;
                    end
                end
                PH_NALFIRST:
                begin
                    if (data_byte[4:0] == NAL_SPS || data_byte[4:0] == NAL_PPS)
                    begin
                        pss_next = 1'b1;
                    end
                    else if (data_byte[4:0] == NAL_IDR && !pss_reg)
                    begin
                        pss_next        = 1'b1;
                        group.insert_ps = 1'b1;
                    end
                    group.start_code = 1'b1;
                    group.data       = 1'b1;
                    group.data_byte  = data_byte;
                    left_next        = left_reg - 24'd1;
                    phase_next       = (left_reg == 24'd1) ? PH_LENGTH : PH_NALBODY;
                end
                PH_NALBODY:
                begin
                    group.data      = 1'b1;
                    group.data_byte = data_byte;
                    left_next       = left_reg - 24'd1;
                    if (left_reg == 24'd1)
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_RAW:
                begin
                    group.data      = 1'b1;
                    group.data_byte = data_byte;
                end
                default:
                begin
                end
            endcase
        end

        if (open)
        begin
            pos_inc = {1'b0, pos_base} + 25'd1;
            if (pos_inc >= {1'b0, len_next})
            begin
                group.end_report = 1'b1;
                group.status     = err_next;
                group.dts        = ts_next;
                if (err_next == ST_NALU_OK || err_next == ST_BAD_SIZE)
                begin
                    group.pts = ts_next + {8'd0, ct_next};
                end
                else
                begin
                    group.pts = ts_next;
                end
                phase_next = PH_IDLE;
                pos_next   = pos_base;
            end
            else
            begin
                pos_next = pos_inc[23:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            lbs_reg       <= '0;
            left_reg      <= '0;
            pss_reg       <= 1'b0;
            kind_zero_reg <= 1'b1;
            ct_reg        <= '0;
            ts_reg        <= '0;
            len_reg       <= '0;
            err_reg       <= '0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            lbs_reg       <= lbs_next;
            left_reg      <= left_next;
            pss_reg       <= pss_next;
            kind_zero_reg <= kind_zero_next;
            ct_reg        <= ct_next;
            ts_reg        <= ts_next;
            len_reg       <= len_next;
            err_reg       <= err_next;
        end
    end

endmodule

>>> rtl/core/flv_annexb_checker.sv
`include "flv_avc_tag_to_annexb_top_defines.svh"

module flv_annexb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       is_data,
    input logic       insert_parameter_sets,
    input logic       end_of_tag,
    input logic [2:0] tag_status
);

    `FLV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `FLV_ASSERT_SAME(a_idle_ready, clk, rst_n, !out_valid, in_ready)
    `FLV_ASSERT_SAME(a_report_form, clk, rst_n, out_valid && end_of_tag, !is_data && out_byte == 8'd0)
    `FLV_ASSERT_SAME(a_ins_form, clk, rst_n, out_valid && insert_parameter_sets, is_data && out_byte == 8'd0)
    `FLV_ASSERT_SAME(a_data_status, clk, rst_n, out_valid && is_data, tag_status == 3'd0 && !end_of_tag)

endmodule

bind flv_avc_tag_to_annexb_top flv_annexb_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_ready              (tag_stream.ready),
    .out_valid             (annexb_stream.valid),
    .out_ready             (annexb_stream.ready),
    .out_byte              (annexb_stream.out_byte),
    .is_data               (annexb_stream.is_data),
    .insert_parameter_sets (annexb_stream.insert_parameter_sets),
    .end_of_tag            (annexb_stream.end_of_tag),
    .tag_status            (annexb_stream.tag_status)
);

>>> tb/flv_avc_tag_to_annexb_top_tb.sv
module flv_avc_tag_to_annexb_top_tb;
    import flv_annexb_pkg::*;

    // codes of the flv / avc byte stream
    localparam logic [3:0] CODEC_AVC          = 4'd7;
    localparam logic [7:0] PKT_SEQ_HEADER     = 8'd0;
    localparam logic [4:0] NAL_TYPE_IDR       = 5'd5;
    localparam logic [4:0] NAL_TYPE_SPS       = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS       = 5'd8;
    localparam logic [7:0] START_CODE_LAST    = 8'h01;
    // 5 header bytes plus the 7 fixed bytes of an avc decoder config record
    localparam logic [23:0] SEQ_HEADER_MIN_LEN = 24'd12;
    localparam logic [23:0] AVC_HEADER_LEN     = 24'd5;
    localparam logic [2:0]  LEN_SIZE_RESET     = 3'd4;

    typedef enum logic [2:0] {
        ST_NALU_OK   = 3'd0,
        ST_SEQ_RAW   = 3'd1,
        ST_OTHER_RAW = 3'd2,
        ST_BAD_SIZE  = 3'd3,
        ST_TOO_SHORT = 3'd4
    } tag_status_e;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_HEADER,
        PARSE_LENGTH,
        PARSE_NAL_FIRST,
        PARSE_NAL_BODY,
        PARSE_RAW,
        PARSE_SKIP
    } parse_state_e;

    // one byte of tag payload with its sideband
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_tag;
        logic [23:0] tag_length;
        logic [31:0] timestamp;
    } tag_byte_t;

    // one annex b output transfer
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_data;
        logic        insert_ps;
        logic        end_of_tag;
        logic [2:0]  status;
        logic [31:0] pts;
        logic [31:0] dts;
    } annexb_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CfgWidth-1:0] cfg_wdata = '0;

    flv_annexb_in_if  tag_if ();
    flv_annexb_out_if annexb_if ();

    flv_avc_tag_to_annexb_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .tag_stream   (tag_if),
        .annexb_stream(annexb_if)
    );

    always #1 clk = ~clk;

    // tag bytes waiting for the driver, annex b results waiting for the monitor
    tag_byte_t      tag_bytes_q[$];
    annexb_result_t annexb_expect[$];
    logic [7:0]     tag_body[$];

    // converter state mirrored by the predictor
    logic [2:0]   nal_len_size = LEN_SIZE_RESET;
    logic [23:0]  pos_q        = '0;
    logic [23:0]  tag_len_q    = '0;
    logic [31:0]  ts_q         = '0;
    logic [31:0]  len_acc_q    = '0;
    logic [2:0]   len_seen_q   = '0;
    logic [31:0]  nal_left_q   = '0;
    logic         ps_seen_q    = 1'b0;
    logic [7:0]   kind_q       = '0;
    logic [23:0]  cts_q        = '0;
    tag_status_e  err_q        = ST_NALU_OK;
    parse_state_e phase_q      = PARSE_IDLE;

    // bookkeeping
    int mismatch_count;
    int bytes_queued;
    int tag_bytes_in;
    int annexb_bytes_out;
    int tag_reports;
    int ps_marks;
    int status_count[8];

    // sender burst / gap state and receiver stall pattern
    int burst_left;
    int gap_left;
    bit drain_hold;
    int stall_left;
    int stall_mode;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    endtask

    function automatic void push_annexb_byte(input logic [7:0] v, input logic ins);
        annexb_result_t r;
        r           = '0;
        r.out_byte  = v;
        r.is_data   = 1'b1;
        r.insert_ps = ins;
        annexb_expect.push_back(r);
    endfunction

    // 00 00 00 01, the flag rides on the first zero
    function automatic void push_start_code(input logic ins);
        push_annexb_byte(8'h00, ins);
        push_annexb_byte(8'h00, 1'b0);
        push_annexb_byte(8'h00, 1'b0);
        push_annexb_byte(START_CODE_LAST, 1'b0);
    endfunction

    // works out the annex b results of one accepted tag byte
    function automatic void predict_annexb(input logic [7:0] b, input logic first,
                                           input logic [23:0] tl, input logic [31:0] ts);
        int unsigned    nsz;
        int unsigned    remaining;
        int unsigned    nal_len;
        logic           ins;
        annexb_result_t rep;
        // out of range settings clamp into 1..4
        nsz = (nal_len_size == 3'd0) ? 1 : (nal_len_size > 3'd4) ? 4 : nal_len_size;
        if (first)
        begin
            tag_len_q  = (tl == 24'd0) ? 24'd1 : tl;
            ts_q       = ts;
            pos_q      = '0;
            len_acc_q  = '0;
            len_seen_q = '0;
            nal_left_q = '0;
            ps_seen_q  = 1'b0;
            kind_q     = '0;
            cts_q      = '0;
            if (b[3:0] == CODEC_AVC)
            begin
                if (tag_len_q < AVC_HEADER_LEN)
                begin
                    err_q   = ST_TOO_SHORT;
                    phase_q = PARSE_SKIP;
                end
                else
                begin
                    err_q   = ST_NALU_OK;
                    phase_q = PARSE_HEADER;
                end
            end
            else
            begin
                err_q   = ST_OTHER_RAW;
                phase_q = PARSE_RAW;
            end
        end
        else
        begin
            // stray byte with no tag open
            if (phase_q == PARSE_IDLE)
                return;
            case (phase_q)
                PARSE_HEADER:
                begin
                    if (pos_q == 24'd1)
                    begin
                        kind_q = b;
                    end
                    else
                    begin
                        cts_q = {cts_q[15:0], b};
                        if (pos_q >= 24'd4)
                        begin
                            if (kind_q == PKT_SEQ_HEADER)
                            begin
                                if (tag_len_q > SEQ_HEADER_MIN_LEN)
                                begin
                                    err_q   = ST_SEQ_RAW;
                                    phase_q = PARSE_RAW;
                                end
                                else
                                begin
                                    err_q   = ST_TOO_SHORT;
                                    phase_q = PARSE_SKIP;
                                end
                            end
                            else
                            begin
                                err_q      = ST_NALU_OK;
                                len_acc_q  = '0;
                                len_seen_q = '0;
                                phase_q    = PARSE_LENGTH;
                            end
                        end
                    end
                end
                PARSE_LENGTH:
                begin
                    // a prefix only starts when a nal byte can follow it
                    if (len_seen_q == 3'd0 && !((32'd0 + pos_q + nsz) < tag_len_q))
                    begin
                        phase_q = PARSE_SKIP;
                    end
                    else
                    begin
                        len_acc_q  = {len_acc_q[23:0], b};
                        len_seen_q = len_seen_q + 3'd1;
                        if (len_seen_q >= nsz)
                        begin
                            remaining  = tag_len_q - pos_q - 1;
                            nal_len    = (len_acc_q == 32'd1) ? remaining : len_acc_q;
                            len_acc_q  = '0;
                            len_seen_q = '0;
                            if (nal_len > remaining)
                            begin
                                err_q   = ST_BAD_SIZE;
                                phase_q = PARSE_SKIP;
                            end
                            else if (nal_len == 0)
                            begin
                                push_start_code(1'b0);
                            end
                            else
                            begin
                                nal_left_q = nal_len;
                                phase_q    = PARSE_NAL_FIRST;
                            end
                        end
                    end
                end
                PARSE_NAL_FIRST:
                begin
                    ins = 1'b0;
                    if (b[4:0] == NAL_TYPE_SPS || b[4:0] == NAL_TYPE_PPS)
                    begin
                        ps_seen_q = 1'b1;
                    end
                    else if (b[4:0] == NAL_TYPE_IDR && !ps_seen_q)
                    begin
                        ps_seen_q = 1'b1;
                        ins       = 1'b1;
                    end
                    push_start_code(ins);
                    push_annexb_byte(b, 1'b0);
                    nal_left_q = nal_left_q - 1;
                    phase_q    = (nal_left_q == 0) ? PARSE_LENGTH : PARSE_NAL_BODY;
                end
                PARSE_NAL_BODY:
                begin
                    push_annexb_byte(b, 1'b0);
                    nal_left_q = nal_left_q - 1;
                    if (nal_left_q == 0)
                        phase_q = PARSE_LENGTH;
                end
                PARSE_RAW: push_annexb_byte(b, 1'b0);
                default: ;
            endcase
        end
        // end of tag report after the data of the last byte
        if ((32'd1 + pos_q) >= tag_len_q)
        begin
            rep            = '0;
            rep.end_of_tag = 1'b1;
            rep.status     = err_q;
            rep.pts        = ts_q;
            if (err_q == ST_NALU_OK || err_q == ST_BAD_SIZE)
                rep.pts = ts_q + {8'd0, cts_q};
            rep.dts        = ts_q;
            annexb_expect.push_back(rep);
            phase_q        = PARSE_IDLE;
        end
        else
        begin
            pos_q = pos_q + 24'd1;
        end
    endfunction

    task automatic push_tag_byte(input logic [7:0] b, input logic first,
                                 input logic [23:0] tl, input logic [31:0] ts);
        tag_byte_t t;
        t.data_byte    = b;
        t.first_of_tag = first;
        t.tag_length   = tl;
        t.timestamp    = ts;
        tag_bytes_q.push_back(t);
        bytes_queued++;
    endtask

    // queues tag_body as one tag; later bytes carry random, ignored sideband
    task automatic queue_tag(input logic [23:0] tl, input logic [31:0] ts);
        int i;
        for (i = 0; i < tag_body.size(); i++)
        begin
            if (i == 0)
                push_tag_byte(tag_body[i], 1'b1, tl, ts);
            else
                push_tag_byte(tag_body[i], 1'b0, 24'($urandom), $urandom);
        end
        tag_body.delete();
    endtask

    task automatic make_random_tag();
        int unsigned nsz;
        int unsigned kind_pick;
        int unsigned sel;
        int unsigned nal_count;
        int unsigned count;
        int unsigned k;
        int          j;
        logic [31:0] len_field;
        logic [7:0]  nal_b;
        logic [3:0]  codec;
        logic [23:0] tl;
        nsz       = (nal_len_size == 3'd0) ? 1 : (nal_len_size > 3'd4) ? 4 : nal_len_size;
        kind_pick = $urandom_range(0, 99);
        tag_body.delete();
        if (kind_pick < 65)
        begin
            // avc: nalu packet or sequence header, header bytes first
            tag_body.push_back({4'($urandom), CODEC_AVC});
            if (kind_pick < 50)
                tag_body.push_back(8'($urandom_range(1, 255)));
            else
                tag_body.push_back(PKT_SEQ_HEADER);
            for (k = 0; k < 3; k++)
                tag_body.push_back(8'($urandom));
            if (kind_pick < 50)
            begin
                nal_count = $urandom_range(1, 3);
                for (k = 0; k < nal_count; k++)
                begin
                    sel = $urandom_range(0, 11);
                    if (sel == 0)
                    begin
                        len_field = '0;
                    end
                    else if (sel == 1)
                    begin
                        // nal runs to the end of the tag
                        len_field = 32'd1;
                    end
                    else if (sel == 2)
                    begin
                        // oversize: top bits of the prefix set
                        len_field = $urandom;
                        if (nsz < 4)
                            len_field = len_field & ((32'd1 << (8 * nsz)) - 32'd1);
                        len_field[8*nsz-1 -: 2] = 2'b11;
                    end
                    else
                    begin
                        len_field = $urandom_range(2, 6);
                    end
                    for (j = int'(nsz) - 1; j >= 0; j--)
                        tag_body.push_back(len_field[8*j +: 8]);
                    count = (sel == 0) ? 0 : (sel <= 2) ? $urandom_range(1, 4) : len_field;
                    for (j = 0; j < int'(count); j++)
                    begin
                        nal_b = 8'($urandom);
                        if (j == 0)
                        begin
                            case ($urandom_range(0, 4))
                                0:       nal_b[4:0] = NAL_TYPE_SPS;
                                1:       nal_b[4:0] = NAL_TYPE_PPS;
                                2, 3:    nal_b[4:0] = NAL_TYPE_IDR;
                                default: ;
                            endcase
                        end
                        tag_body.push_back(nal_b);
                    end
                    if (sel == 1 || sel == 2)
                        break;
                end
                // trailing bytes too few for another prefix
                if ($urandom_range(0, 4) == 0)
                begin
                    count = $urandom_range(1, nsz);
                    for (k = 0; k < count; k++)
                        tag_body.push_back(8'($urandom));
                end
            end
            else
            begin
                // sequence header, raw only above 12 bytes
                count = $urandom_range(3, 15);
                for (k = 0; k < count; k++)
                    tag_body.push_back(8'($urandom));
            end
            // mostly exact lengths, a few tags left open or cut short
            case ($urandom_range(0, 19))
                0:       tl = 24'($urandom_range(tag_body.size() + 1, 24'hFF_FFFF));
                1:       tl = 24'($urandom_range(1, tag_body.size() - 1));
                default: tl = 24'(tag_body.size());
            endcase
            queue_tag(tl, $urandom);
        end
        else if (kind_pick < 77)
        begin
            // other codec, passed on raw
            codec = 4'($urandom_range(0, 14));
            if (codec >= CODEC_AVC)
                codec = codec + 4'd1;
            tag_body.push_back({4'($urandom), codec});
            count = $urandom_range(0, 7);
            for (k = 0; k < count; k++)
                tag_body.push_back(8'($urandom));
            tl = 24'(tag_body.size());
            if (tl == 24'd1 && $urandom_range(0, 1) == 0)
                tl = '0;
            queue_tag(tl, $urandom);
        end
        else if (kind_pick < 87)
        begin
            // avc tag shorter than its header
            tag_body.push_back({4'($urandom), CODEC_AVC});
            count = $urandom_range(0, 3);
            for (k = 0; k < count; k++)
                tag_body.push_back(8'($urandom));
            tl = 24'(tag_body.size());
            if (tl == 24'd1 && $urandom_range(0, 1) == 0)
                tl = '0;
            queue_tag(tl, $urandom);
        end
        else
        begin
            // noise: random sideband, stray bytes and restarts
            count = $urandom_range(1, 6);
            for (k = 0; k < count; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    tl = 24'($urandom);
                else
                    tl = 24'($urandom_range(0, 20));
                push_tag_byte(8'($urandom), ($urandom_range(0, 3) == 0), tl, $urandom);
            end
        end
    endtask

    // sample at the falling edge so no same-edge update is missed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (tag_bytes_q.size() != 0 || tag_if.valid || annexb_expect.size() != 0);
        // bytes that cause no result may still sit in the pipeline
        repeat (8) @(posedge clk);
    endtask

    task automatic write_len_size(input logic [2:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        nal_len_size = v;
    endtask

    // driver: bursts of transfers, random gaps, now and then a hold until drained
    always @(posedge clk)
    begin : drive_tag_bytes
        tag_byte_t nxt;
        if (!rst_n)
        begin
            tag_if.valid <= 1'b0;
        end
        else
        begin
            if (tag_if.valid && tag_if.ready)
            begin
                predict_annexb(tag_if.data_byte, tag_if.first_of_tag, tag_if.tag_length,
                               tag_if.timestamp);
                tag_bytes_in++;
            end
            if (!tag_if.valid || tag_if.ready)
            begin
                if (drain_hold && annexb_expect.size() == 0)
                    drain_hold = 1'b0;
                if (gap_left > 0 || drain_hold || tag_bytes_q.size() == 0)
                begin
                    tag_if.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    nxt                 = tag_bytes_q.pop_front();
                    tag_if.valid        <= 1'b1;
                    tag_if.data_byte    <= nxt.data_byte;
                    tag_if.first_of_tag <= nxt.first_of_tag;
                    tag_if.tag_length   <= nxt.tag_length;
                    tag_if.timestamp    <= nxt.timestamp;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 48);
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        // a quarter of the bursts run straight into the next one
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                        drain_hold = ($urandom_range(0, 15) == 0);
                    end
                end
            end
        end
    end

    // monitor: checks each result transfer, stalls on its own pattern
    always @(posedge clk)
    begin : check_annexb
        annexb_result_t want;
        if (!rst_n)
        begin
            annexb_if.ready <= 1'b0;
        end
        else
        begin
            if (annexb_if.valid && annexb_if.ready)
            begin
                if (annexb_expect.size() == 0)
                begin
                    report_mismatch("result with nothing expected", '0,
                                    {23'd0, annexb_if.is_data, annexb_if.out_byte});
                end
                else
                begin
                    want = annexb_expect.pop_front();
                    if (annexb_if.out_byte !== want.out_byte)
                        report_mismatch("out_byte", want.out_byte, annexb_if.out_byte);
                    if (annexb_if.is_data !== want.is_data)
                        report_mismatch("is_data", want.is_data, annexb_if.is_data);
                    if (annexb_if.insert_parameter_sets !== want.insert_ps)
                        report_mismatch("insert_parameter_sets", want.insert_ps,
                                        annexb_if.insert_parameter_sets);
                    if (annexb_if.end_of_tag !== want.end_of_tag)
                        report_mismatch("end_of_tag", want.end_of_tag, annexb_if.end_of_tag);
                    if (annexb_if.tag_status !== want.status)
                        report_mismatch("tag_status", want.status, annexb_if.tag_status);
                    if (annexb_if.pts !== want.pts)
                        report_mismatch("pts", want.pts, annexb_if.pts);
                    if (annexb_if.dts !== want.dts)
                        report_mismatch("dts", want.dts, annexb_if.dts);
                    if (want.end_of_tag)
                    begin
                        tag_reports++;
                        status_count[want.status]++;
                    end
                    else
                    begin
                        annexb_bytes_out++;
                    end
                    if (want.insert_ps)
                        ps_marks++;
                end
            end
            // stall mode is redrawn whenever its random run counter runs out
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 64);
            end
            stall_left--;
            case (stall_mode)
                0:       annexb_if.ready <= 1'b1;
                1:       annexb_if.ready <= ($urandom_range(0, 9) < 7);
                2:       annexb_if.ready <= ($urandom_range(0, 3) == 0);
                default: annexb_if.ready <= stall_left[3];
            endcase
        end
    end

    initial
    begin : run_stimulus
        logic [2:0] len_settings[8];
        int         p;
        len_settings = '{3'd2, 3'd0, 3'd3, 3'd6, 3'd4, 3'd7, 3'd1, 3'd5};

        tag_if.valid        = 1'b0;
        tag_if.data_byte    = '0;
        tag_if.first_of_tag = 1'b0;
        tag_if.tag_length   = '0;
        tag_if.timestamp    = '0;
        annexb_if.ready     = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed, 4-byte prefixes from reset
        // other codec with zero tag length acts as one byte
        push_tag_byte(8'h02, 1'b1, 24'd0, 32'hFFFF_FFFF);
        // stray byte while no tag is open
        push_tag_byte(8'hFF, 1'b0, 24'hFF_FFFF, 32'h0);
        // avc tag too short for its header
        push_tag_byte(8'hF7, 1'b1, 24'd1, 32'h1234_5678);
        // idr with no parameter sets, maximum composition time, pts wraps
        tag_body = '{8'h17, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'hAB};
        queue_tag(24'd11, 32'hFFFF_FF00);

        // directed, 1-byte prefixes: empty nal, then a nal running to the end
        wait_drained();
        write_len_size(3'd1);
        tag_body = '{8'h17, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h80};
        queue_tag(24'd9, 32'h0000_0001);

        // random tags, one batch per prefix size setting, out of range ones too
        for (p = 0; p < 8; p++)
        begin
            wait_drained();
            write_len_size(len_settings[p]);
            bytes_queued = 0;
            while (bytes_queued < 24)
                make_random_tag();
        end

        wait_drained();
        $display("sent %0d tag bytes under every prefix size code: %0d annex b bytes",
                 tag_bytes_in, annexb_bytes_out);
        $display("%0d reports (ok %0d seq %0d other %0d bad %0d short %0d), %0d ps marks",
                 tag_reports, status_count[ST_NALU_OK], status_count[ST_SEQ_RAW],
                 status_count[ST_OTHER_RAW], status_count[ST_BAD_SIZE],
                 status_count[ST_TOO_SHORT], ps_marks);
        if (mismatch_count == 0)
            $display("flv_avc_tag_to_annexb_top regression: pass");
        else
            $display("flv_avc_tag_to_annexb_top regression: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #400000;
        $display("flv_avc_tag_to_annexb_top regression: fail");
        $finish;
    end

endmodule
